### rtl/rar_pkg.sv
// Package for the rational adder: sequencer states and output field widths.
// Used by every file of the block; depends on nothing.
`default_nettype none
package rar_pkg;

   localparam int NUM_OUT_W = 33;
   localparam int DEN_OUT_W = 31;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD1,
      ST_DIVA,
      ST_DIVB,
      ST_MULA,
      ST_MULB,
      ST_MULD,
      ST_COMB,
      ST_GCD2,
      ST_DIVM,
      ST_DIVD,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

### rtl/rar_if.sv
// Handshake interfaces for the request and response channels of the adder.
// Depends on rar_pkg for the output field widths.
`default_nettype none
interface rar_req_if #(parameter int IN_WIDTH = 16);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] num_a;
   logic signed [IN_WIDTH-1:0] den_a;
   logic signed [IN_WIDTH-1:0] num_b;
   logic signed [IN_WIDTH-1:0] den_b;
   modport source (output valid, num_a, den_a, num_b, den_b, input ready);
   modport sink (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rar_rsp_if import rar_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [NUM_OUT_W-1:0] sum_num;
   logic        [DEN_OUT_W-1:0] sum_den;
   logic                        bad_input;
   modport source (output valid, sum_num, sum_den, bad_input, input ready);
   modport sink (input valid, sum_num, sum_den, bad_input, output ready);
endinterface
`default_nettype wire

### rtl/rational_add_reduce.sv
// Rational adder: adds two signed fractions and returns the sum in lowest terms.
// One request at a time, ready only when idle: four divider runs, three multiplier runs,
// a combine step that may first swap the terms, and two binary GCD runs, all on one
// shared adder. A zero denominator gives a response in the cycle after the request is taken.
// The block is ready again in the cycle after the response is taken; reset returns to idle, none pending.
`default_nettype none
module rational_add_reduce import rar_pkg::*; #(
   parameter int IN_WIDTH = 16
) (
   input  wire       clock,
   input  wire       reset,
   rar_req_if.sink   req_port,
   rar_rsp_if.source rsp_port
);

   // Internal word holds the widest intermediate: the sum of two products.
   localparam int L  = 2 * IN_WIDTH + 2;
   localparam int CW = $clog2(L + 1);
   localparam int EW = L + NUM_OUT_W;

   state_type state_ff, state_in;

   // Shared work registers: x and y are the operands, z the remainder or accumulator.
   logic [L-1:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in, g_ff, g_in;
   logic [CW-1:0]       cnt_ff, cnt_in, k_ff, k_in;
   // Operand and result storage for the request in flight.
   logic [IN_WIDTH-1:0] na_ff, na_in, nb_ff, nb_in, da_ff, da_in, db_ff, db_in;
   logic [IN_WIDTH-1:0] qa_ff, qa_in;
   logic [L-1:0]        ta_ff, ta_in, tb_ff, tb_in, den_ff, den_in;
   logic                sa_ff, sa_in, sb_ff, sb_in, bad_ff, bad_in;

   // The one arithmetic unit of the block.
   logic [L-1:0] add_a, add_b;
   logic         add_sub;
   logic [L:0]   add_sum;
   logic         a_ge_b;

   logic [L-1:0]        div_rem;
   logic [IN_WIDTH-1:0] mag_na, mag_da, mag_nb, mag_db;
   logic                gcd_done;
   logic [EW-1:0]       ext_mag, ext_num;

   assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {{L{1'b0}}, add_sub};
   assign a_ge_b  = add_sum[L];

   // Remainder shifted left by one with the next dividend bit brought in.
   assign div_rem = {z_ff[L-2:0], x_ff[L-1]};

   // Magnitudes at full precision so the most negative input is exact.
   assign mag_na = req_port.num_a[IN_WIDTH-1] ? -req_port.num_a : req_port.num_a;
   assign mag_da = req_port.den_a[IN_WIDTH-1] ? -req_port.den_a : req_port.den_a;
   assign mag_nb = req_port.num_b[IN_WIDTH-1] ? -req_port.num_b : req_port.num_b;
   assign mag_db = req_port.den_b[IN_WIDTH-1] ? -req_port.den_b : req_port.den_b;

   // The binary GCD ends once y is empty and all common factors of two are back in x.
   assign gcd_done = (x_ff != '0) && (y_ff == '0) && (k_ff == '0);

   always_comb begin
      add_a   = x_ff;
      add_b   = y_ff;
      add_sub = 1'b1;
      case (state_ff)
         ST_DIVA, ST_DIVB, ST_DIVM, ST_DIVD: begin
            add_a = div_rem;
         end
         ST_MULA, ST_MULB, ST_MULD: begin
            add_a   = z_ff;
            add_b   = x_ff;
            add_sub = 1'b0;
         end
         ST_COMB: begin
            add_a   = ta_ff;
            add_b   = tb_ff;
            add_sub = (sa_ff != sb_ff);
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               state_in = ((mag_da == '0) || (mag_db == '0)) ? ST_OUT : ST_GCD1;
            end
         end
         ST_GCD1: if (gcd_done) state_in = ST_DIVA;
         ST_DIVA: if (cnt_ff == CW'(1)) state_in = ST_DIVB;
         ST_DIVB: if (cnt_ff == CW'(1)) state_in = ST_MULA;
         ST_MULA: if (cnt_ff == CW'(1)) state_in = ST_MULB;
         ST_MULB: if (cnt_ff == CW'(1)) state_in = ST_MULD;
         ST_MULD: if (cnt_ff == CW'(1)) state_in = ST_COMB;
         ST_COMB: if ((sa_ff == sb_ff) || a_ge_b) state_in = ST_GCD2;
         ST_GCD2: if (gcd_done) state_in = ST_DIVM;
         ST_DIVM: if (cnt_ff == CW'(1)) state_in = ST_DIVD;
         ST_DIVD: if (cnt_ff == CW'(1)) state_in = ST_OUT;
         ST_OUT:  if (rsp_port.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath: each state steps its operation and, on its last step,
   // stores the result and loads the operands of the next one.
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      g_in   = g_ff;
      cnt_in = cnt_ff;
      k_in   = k_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      da_in  = da_ff;
      db_in  = db_ff;
      qa_in  = qa_ff;
      ta_in  = ta_ff;
      tb_in  = tb_ff;
      den_in = den_ff;
      sa_in  = sa_ff;
      sb_in  = sb_ff;
      bad_in = bad_ff;
      case (state_ff)
         ST_IDLE: begin
            na_in  = mag_na;
            nb_in  = mag_nb;
            da_in  = mag_da;
            db_in  = mag_db;
            sa_in  = (mag_na != '0) && (req_port.num_a[IN_WIDTH-1] != req_port.den_a[IN_WIDTH-1]);
            sb_in  = (mag_nb != '0) && (req_port.num_b[IN_WIDTH-1] != req_port.den_b[IN_WIDTH-1]);
            bad_in = (mag_da == '0) || (mag_db == '0);
            x_in   = L'(mag_da);
            y_in   = L'(mag_db);
            k_in   = '0;
            ta_in  = '0;
            den_in = '0;
            sa_in  = bad_in ? 1'b0 : sa_in;
         end
         ST_GCD1, ST_GCD2: begin
            if (x_ff == '0) begin
               x_in = y_ff;
               y_in = '0;
            end else if (y_ff == '0) begin
               if (k_ff != '0) begin
                  x_in = {x_ff[L-2:0], 1'b0};
                  k_in = k_ff - CW'(1);
               end else begin
                  g_in   = x_ff;
                  y_in   = x_ff;
                  z_in   = '0;
                  cnt_in = CW'(L);
                  x_in   = (state_ff == ST_GCD1) ? L'(da_ff) : ta_ff;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (a_ge_b) begin
               x_in = add_sum[L-1:0];
            end else begin
               x_in = y_ff;
               y_in = x_ff;
            end
         end
         ST_DIVA, ST_DIVB, ST_DIVM, ST_DIVD: begin
            z_in   = a_ge_b ? add_sum[L-1:0] : div_rem;
            x_in   = {x_ff[L-2:0], a_ge_b};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               z_in = '0;
               y_in = g_ff;
               case (state_ff)
                  ST_DIVA: begin
                     qa_in  = x_in[IN_WIDTH-1:0];
                     x_in   = L'(db_ff);
                     cnt_in = CW'(L);
                  end
                  ST_DIVB: begin
                     // The quotient db/g becomes the multiplier of num_a.
                     y_in   = L'(x_in[IN_WIDTH-1:0]);
                     x_in   = L'(na_ff);
                     cnt_in = CW'(IN_WIDTH);
                  end
                  ST_DIVM: begin
                     ta_in  = x_in;
                     x_in   = den_ff;
                     cnt_in = CW'(L);
                  end
                  default: begin
                     den_in = x_in;
                  end
               endcase
            end
         end
         ST_MULA, ST_MULB, ST_MULD: begin
            z_in   = y_ff[0] ? add_sum[L-1:0] : z_ff;
            x_in   = {x_ff[L-2:0], 1'b0};
            y_in   = y_ff >> 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               z_in   = '0;
               cnt_in = CW'(IN_WIDTH);
               case (state_ff)
                  ST_MULA: begin
                     ta_in = y_ff[0] ? add_sum[L-1:0] : z_ff;
                     x_in  = L'(nb_ff);
                     y_in  = L'(qa_ff);
                  end
                  ST_MULB: begin
                     tb_in = y_ff[0] ? add_sum[L-1:0] : z_ff;
                     x_in  = L'(qa_ff);
                     y_in  = L'(db_ff);
                  end
                  default: begin
                     den_in = y_ff[0] ? add_sum[L-1:0] : z_ff;
                  end
               endcase
            end
         end
         ST_COMB: begin
            if ((sa_ff == sb_ff) || a_ge_b) begin
               ta_in = add_sum[L-1:0];
               x_in  = add_sum[L-1:0];
               y_in  = den_ff;
               k_in  = '0;
            end else begin
               // The second term is larger: swap the terms and their signs.
               ta_in = tb_ff;
               tb_in = ta_ff;
               sa_in = sb_ff;
               sb_in = sa_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      g_ff   <= g_in;
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
      na_ff  <= na_in;
      nb_ff  <= nb_in;
      da_ff  <= da_in;
      db_ff  <= db_in;
      qa_ff  <= qa_in;
      ta_ff  <= ta_in;
      tb_ff  <= tb_in;
      den_ff <= den_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      bad_ff <= bad_in;
   end

   // The sign sits on the numerator; a zero sum keeps a plus sign.
   assign ext_mag = EW'(ta_ff);
   assign ext_num = (sa_ff && (ta_ff != '0)) ? -ext_mag : ext_mag;

   assign req_port.ready     = (state_ff == ST_IDLE);
   assign rsp_port.valid     = (state_ff == ST_OUT);
   assign rsp_port.sum_num   = ext_num[NUM_OUT_W-1:0];
   assign rsp_port.sum_den   = DEN_OUT_W'(EW'(den_ff));
   assign rsp_port.bad_input = bad_ff;

endmodule
`default_nettype wire

### rtl/rar_chk.sv
// Port-level checker for the rational adder, bound to the top level.
// Depends on rar_pkg for the output field widths.
`default_nettype none
module rar_chk import rar_pkg::*; (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire signed [NUM_OUT_W-1:0] sum_num,
   input wire        [DEN_OUT_W-1:0] sum_den,
   input wire                        bad_input
);

   // Only one request is in flight: no new request while a response waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   // Once a request is taken, the block is busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready held after a request");

   // A waiting response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(sum_num) && $stable(sum_den)
         && $stable(bad_input))) else $error("response changed while waiting");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && bad_input) |-> (sum_num == '0 && sum_den == '0))
      else $error("error response carries a value");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !bad_input) |-> (sum_den != '0))
      else $error("zero denominator on a good response");

endmodule

bind rational_add_reduce rar_chk u_rar_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .sum_num   (rsp_port.sum_num),
   .sum_den   (rsp_port.sum_den),
   .bad_input (rsp_port.bad_input)
);
`default_nettype wire

### dv/rar_scoreboard.sv
// Scoreboard for the rational adder testbench: predicts each reduced sum and
// checks the responses in order. Depends on rar_pkg for the output widths.
`timescale 1ns / 1ps
import rar_pkg::*;

typedef struct {
   logic signed [NUM_OUT_W-1:0] sum_num;
   logic        [DEN_OUT_W-1:0] sum_den;
   logic                        bad_input;
} rar_sum_type;

class rar_scoreboard;
   rar_sum_type pending_sums[$];
   int          error_count;

   function new();
      error_count = 0;
   endfunction

   static function longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function void note_request(logic signed [15:0] na, logic signed [15:0] da,
                              logic signed [15:0] nb, logic signed [15:0] db);
      rar_sum_type s;
      longint ma, mda, mb, mdb, g, ta, tb, den, mag, g2, num;
      bit sa, sb, neg;
      ma = na; mda = da; mb = nb; mdb = db;
      s.bad_input = 1'b0;
      if (mda == 0 || mdb == 0) begin
         s.sum_num = '0;
         s.sum_den = '0;
         s.bad_input = 1'b1;
      end else begin
         sa = (ma != 0) && ((ma < 0) != (mda < 0));
         sb = (mb != 0) && ((mb < 0) != (mdb < 0));
         if (ma < 0) ma = -ma;
         if (mda < 0) mda = -mda;
         if (mb < 0) mb = -mb;
         if (mdb < 0) mdb = -mdb;
         g = euclid_gcd(mda, mdb);
         ta = ma * (mdb / g);
         tb = mb * (mda / g);
         den = (mda / g) * mdb;
         if (sa == sb) begin
            mag = ta + tb; neg = sa;
         end else if (ta >= tb) begin
            mag = ta - tb; neg = sa;
         end else begin
            mag = tb - ta; neg = sb;
         end
         if (mag == 0) neg = 0;
         g2 = euclid_gcd(mag, den);
         mag = mag / g2;
         den = den / g2;
         num = neg ? -mag : mag;
         s.sum_num = num[NUM_OUT_W-1:0];
         s.sum_den = den[DEN_OUT_W-1:0];
      end
      pending_sums.push_back(s);
   endfunction

   task report(string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task check_response(logic signed [NUM_OUT_W-1:0] num, logic [DEN_OUT_W-1:0] den,
                       logic bad);
      rar_sum_type e;
      if (pending_sums.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      e = pending_sums.pop_front();
      if (num !== e.sum_num)
         report($sformatf("sum_num got %0d expected %0d", num, e.sum_num));
      if (den !== e.sum_den)
         report($sformatf("sum_den got %0d expected %0d", den, e.sum_den));
      if (bad !== e.bad_input)
         report($sformatf("bad_input got %0b expected %0b", bad, e.bad_input));
   endtask
endclass

### dv/tb_rational_add_reduce.sv
// Top level of the rational adder testbench: drives directed and random
// requests with random gaps and stalls. Depends on rar_pkg, rar_if, the scoreboard.
`timescale 1ns / 1ps
module tb_rational_add_reduce import rar_pkg::*; ();

   localparam int NUM_RANDOM = 650;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;
   bit sending_done = 0;
   bit long_hold = 0;

   rar_req_if #(.IN_WIDTH(16)) req_bus ();
   rar_rsp_if rsp_bus ();
   rar_scoreboard sums = new();

   rational_add_reduce #(.IN_WIDTH(16)) dut (
      .clock(clock), .reset(reset), .req_port(req_bus.sink), .rsp_port(rsp_bus.source)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The cycle counter doubles as the watchdog for a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Requests are noted and responses checked at the rising edge, where the
   // handshake takes place.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sums.note_request(req_bus.num_a, req_bus.den_a, req_bus.num_b, req_bus.den_b);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sums.check_response(rsp_bus.sum_num, rsp_bus.sum_den, rsp_bus.bad_input);
   end

   // Sends one request after a random gap, or at once if no_gap is set; holds it until the block takes it.
   task send_request(logic signed [15:0] na, logic signed [15:0] da,
                     logic signed [15:0] nb, logic signed [15:0] db, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.num_a = na;
      req_bus.den_a = da;
      req_bus.num_b = nb;
      req_bus.den_b = db;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Half the values are small and give deep reductions; the rest cover the full range and its extremes.
   function logic signed [15:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(0, 24))) - 16'sd12;
         2: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
         default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
      endcase
   endfunction

   initial begin
      logic signed [15:0] na, da, nb, db;
      req_bus.valid = 1'b0;
      req_bus.num_a = '0;
      req_bus.den_a = '0;
      req_bus.num_b = '0;
      req_bus.den_b = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes, zero denominators, zero sums and plain reduction.
      send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_request(16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 0);
      send_request(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 0);
      send_request(16'sh7fff, 16'sh8000, 16'sh7ffe, 16'sh7ffd, 0);
      send_request(16'sd1, 16'sd0, 16'sd1, 16'sd1, 0);
      send_request(16'sd1, 16'sd1, 16'sd1, 16'sd0, 0);
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
      send_request(16'sd3, 16'sd4, -16'sd3, 16'sd4, 0);
      send_request(16'sd3, -16'sd4, 16'sd3, 16'sd4, 0);
      send_request(16'sd0, -16'sd5, 16'sd0, 16'sd7, 0);
      send_request(16'sd6, 16'sd8, 16'sd0, 16'sd1, 0);
      send_request(-16'sd6, -16'sd8, 16'sd0, 16'sd1, 0);
      send_request(16'sd1, 16'sd6, 16'sd1, 16'sd3, 0);
      send_request(-16'sd1, 16'sd2, 16'sd1, -16'sd3, 0);
      send_request(16'shffff, 16'shffff, 16'sd1, 16'sd1, 0);
      send_request(16'sh5555, 16'shaaaa, 16'sh2aaa, 16'sh5555, 0);

      // Back-to-back requests while the receiver holds off stall the request side, as the block holds one request.
      long_hold = 1;
      for (int i = 0; i < 8; i++)
         send_request(pick_value(), pick_value(), pick_value(), pick_value(), 1);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         na = pick_value();
         nb = pick_value();
         da = pick_value();
         db = pick_value();
         // Keep zero denominators to an occasional request.
         if (da == 0 && $urandom_range(0, 3) != 0) da = 16'sd1;
         if (db == 0 && $urandom_range(0, 3) != 0) db = -16'sd1;
         send_request(na, da, nb, db, $urandom_range(0, 3) == 0);
      end
      sending_done = 1;
   end

   // Response side: a random stall before each response, plus one long hold.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_bus.ready = 1'b0;
            repeat (600) @(negedge clock);
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // End of run: every request answered, then a drain period for strays.
   initial begin
      wait (sending_done);
      while (sums.pending_sums.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sums.error_count == 0 && sums.pending_sums.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### sim.f
rtl/rar_pkg.sv
rtl/rar_if.sv
rtl/rational_add_reduce.sv
rtl/rar_chk.sv
dv/rar_scoreboard.sv
dv/tb_rational_add_reduce.sv
